// ----- src/glid_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glid_pkg
// Types and constants for the GLONASS interval/day to Julian day converter.
// ----------------------------------------------------------------------------
package glid_pkg;

	typedef enum logic [0:0] {
		OP_TO_JD   = 1'b0,
		OP_FROM_JD = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_EARLY_YEAR = 2'd1,
		ERR_INTERVAL   = 2'd2
	} err_t;

	typedef struct packed {
		logic        op;
		logic [4:0]  interval_number;
		logic [10:0] interval_day;
		logic [21:0] julian_day_in;
		logic [26:0] day_millis_in;
	} conv_in_t;

	typedef struct packed {
		logic [21:0] julian_day_out;
		logic [4:0]  interval_out;
		logic [10:0] interval_day_out;
		logic [26:0] day_millis_out;
		logic [1:0]  error_code;
	} conv_out_t;

	// Julian day of 1 Jan 1996
	localparam logic [21:0] JAN1_1996       = 22'd2450084;
	// first Julian day past the last valid interval (1 Jan 2120)
	localparam logic [21:0] JD_LIMIT        = 22'd2495374;
	localparam logic [4:0]  NO_LEAP_N4      = 5'd27;
	localparam logic [8:0]  DAYS_YEAR       = 9'd365;
	localparam logic [8:0]  DAYS_LEAP       = 9'd366;
	localparam logic [10:0] DAYS_TWO_YEARS  = 11'd730;
	localparam logic [15:0] DAYS_INTERVAL   = 16'd1461;
	// day offset from 1996 where the interval after 2100 begins
	localparam logic [15:0] POST_2100_START = 16'd39446;
	// year offset of 2100 from 1996
	localparam logic [6:0]  YEAR_2100_OFF   = 7'd104;
	// ceil(2^26 / 1461), exact floor for offsets below 94519
	localparam logic [31:0] DIV_MUL         = 32'd45934;
	localparam int          DIV_SHIFT       = 26;

	typedef struct packed {
		logic        op;
		logic [1:0]  err;
		logic [26:0] millis;
		logic [4:0]  n4m1;
		logic [1:0]  yi;
		logic [10:0] doy;
		logic [15:0] d2;
	} stage1_t;

	typedef struct packed {
		logic        op;
		logic [1:0]  err;
		logic [26:0] millis;
		logic [21:0] jan1;
		logic [10:0] doy;
		logic [15:0] d2;
		logic [4:0]  q;
	} stage2_t;

endpackage

`default_nettype wire

// ----- src/glonass_interval_day_julian_convert.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glonass_interval_day_julian_convert
// Converts GLONASS N4/day-in-interval to Julian day number and back.
// ----------------------------------------------------------------------------
// Fully pipelined: a new word is taken on every cycle that start is high and
// busy is low, and busy is high only while in reset and the cycle after.
// Each word's result appears on result with done high, in order, after passing
// through the three pipeline registers (decode, the 1 Jan day and the reciprocal
// multiply for the interval index, final assembly). Results must be captured
// when done is high.
module glonass_interval_day_julian_convert import glid_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire conv_in_t request,
	output logic          done,
	output conv_out_t     result
);

	logic    ready_q;
	logic    v_s1;
	logic    v_s2;
	stage1_t data_s1;
	stage2_t data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	assign busy = !ready_q;

	glid_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (start && ready_q),
		.request (request),
		.v_s1    (v_s1),
		.data_s1 (data_s1)
	);

	glid_calc u_calc (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s1    (v_s1),
		.data_s1 (data_s1),
		.v_s2    (v_s2),
		.data_s2 (data_s2)
	);

	glid_finish u_finish (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s2    (v_s2),
		.data_s2 (data_s2),
		.v_s3    (done),
		.data_s3 (result)
	);

endmodule

`default_nettype wire

// ----- src/glid_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glid_decode
// Stage 1: year-in-interval split, range checks and day offset from 1996.
// ----------------------------------------------------------------------------
module glid_decode import glid_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     valid,
	input  wire conv_in_t request,
	output logic          v_s1,
	output stage1_t       data_s1
);

	stage1_t     nxt;
	logic [10:0] lim1;
	logic [10:0] lim2;
	logic [10:0] lim3;
	logic [15:0] dofs;

	always_comb begin
		nxt        = '0;
		nxt.op     = request.op;
		nxt.millis = request.day_millis_in;
		nxt.n4m1   = request.interval_number - 5'd1;
		lim1 = (request.interval_number == NO_LEAP_N4) ? 11'(DAYS_YEAR) : 11'(DAYS_LEAP);
		lim2 = lim1 + 11'(DAYS_YEAR);
		lim3 = lim1 + DAYS_TWO_YEARS;
		if (request.interval_day <= lim1) begin
			nxt.yi  = 2'd0;
			nxt.doy = request.interval_day;
		end else if (request.interval_day <= lim2) begin
			nxt.yi  = 2'd1;
			nxt.doy = request.interval_day - lim1;
		end else if (request.interval_day <= lim3) begin
			nxt.yi  = 2'd2;
			nxt.doy = request.interval_day - lim2;
		end else begin
			nxt.yi  = 2'd3;
			nxt.doy = request.interval_day - lim3;
		end
		dofs   = 16'(request.julian_day_in - JAN1_1996);
		nxt.d2 = dofs + 16'(dofs >= POST_2100_START);
		if (request.op == OP_TO_JD) begin
			nxt.err = (request.interval_number == 5'd0) ? ERR_INTERVAL : ERR_NONE;
		end else if (request.julian_day_in < JAN1_1996) begin
			nxt.err = ERR_EARLY_YEAR;
		end else if (request.julian_day_in >= JD_LIMIT) begin
			nxt.err = ERR_INTERVAL;
		end else begin
			nxt.err = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

endmodule

`default_nettype wire

// ----- src/glid_calc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glid_calc
// Stage 2: Julian day of 1 Jan for op 0, interval index by reciprocal
// multiply for op 1.
// ----------------------------------------------------------------------------
module glid_calc import glid_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    v_s1,
	input  wire stage1_t data_s1,
	output logic         v_s2,
	output stage2_t      data_s2
);

	logic [6:0]  off;
	logic [5:0]  leaps;
	logic [15:0] yr_days;
	logic [31:0] prod;
	stage2_t     nxt;

	always_comb begin
		off     = {data_s1.n4m1, data_s1.yi};
		leaps   = 6'((8'(off) + 8'd3) >> 2) - 6'(off > YEAR_2100_OFF);
		yr_days = 16'(off) * 16'(DAYS_YEAR);
		prod    = 32'(data_s1.d2) * DIV_MUL;
		nxt        = '0;
		nxt.op     = data_s1.op;
		nxt.err    = data_s1.err;
		nxt.millis = data_s1.millis;
		nxt.doy    = data_s1.doy;
		nxt.d2     = data_s1.d2;
		nxt.jan1   = JAN1_1996 + 22'(yr_days) + 22'(leaps);
		nxt.q      = 5'(prod >> DIV_SHIFT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		data_s2 <= nxt;
	end

endmodule

`default_nettype wire

// ----- src/glid_finish.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glid_finish
// Stage 3: final Julian day, interval remainder and result word assembly.
// ----------------------------------------------------------------------------
module glid_finish import glid_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    v_s2,
	input  wire stage2_t data_s2,
	output logic         v_s3,
	output conv_out_t    data_s3
);

	logic [15:0] ivl_base;
	logic [10:0] rem;
	conv_out_t   nxt;

	always_comb begin
		ivl_base = 16'(data_s2.q) * DAYS_INTERVAL;
		rem      = 11'(data_s2.d2 - ivl_base);
		nxt                = '0;
		nxt.day_millis_out = data_s2.millis;
		nxt.error_code     = data_s2.err;
		if (data_s2.err == ERR_NONE) begin
			if (data_s2.op == OP_TO_JD) begin
				nxt.julian_day_out = data_s2.jan1 + 22'(data_s2.doy) - 22'd1;
			end else begin
				nxt.interval_out     = data_s2.q + 5'd1;
				nxt.interval_day_out = rem + 11'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		data_s3 <= nxt;
	end

endmodule

`default_nettype wire

// ----- src/glid_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// glid_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module glid_checker import glid_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire conv_in_t  request,
	input wire logic      done,
	input wire conv_out_t result
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("accepted word did not complete in three cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without an accepted word");

	a_millis: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.day_millis_out == $past(request.day_millis_in, 3)))
		else $error("milliseconds not carried through");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.error_code != ERR_NONE)) |->
		((result.julian_day_out == '0) && (result.interval_out == '0) &&
		 (result.interval_day_out == '0)))
		else $error("nonzero result fields on error");

	a_op_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(request.op == OP_TO_JD, 3)) |->
		((result.interval_out == '0) && (result.interval_day_out == '0) &&
		 (result.error_code != ERR_EARLY_YEAR)))
		else $error("op 0 result carries op 1 fields");

endmodule

bind glonass_interval_day_julian_convert glid_checker u_glid_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);

`default_nettype wire

// ----- tb/tb_glonass_interval_day_julian_convert.sv -----
// ----------------------------------------------------------------------------
// tb_glonass_interval_day_julian_convert
// Self-checking bench for the GLONASS N4/day to Julian day converter. Every
// accepted word is run through a behavioral model of the conversion, and each
// strobed result is compared field by field, in order, with the model's output.
// The directed edge cases come first. Random words follow, mostly well formed,
// with idle bursts and one full drain. The run ends with back-to-back words.
// ----------------------------------------------------------------------------
module tb_glonass_interval_day_julian_convert;
	import glid_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DAY_MS      = 86400000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	conv_in_t  request;
	logic      done;
	conv_out_t result;

	conv_out_t conversions_in_flight[$];
	int        mismatches;
	int        results_seen;
	int        to_jd_words;
	int        from_jd_words;
	int        early_year_words;
	int        bad_interval_words;
	int        quiet_cycles;
	int        idle_odds;

	glonass_interval_day_julian_convert uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Julian day of 1 January of year y (integer Fliegel/Van Flandern form)
	function automatic longint jan1_julian(longint y);
		return -32074 + (1461 * (y + 4799)) / 4 + 336 - (3 * ((y + 4899) / 100)) / 4;
	endfunction

	function automatic longint year_of_julian(longint jd);
		longint l, n, i, j, k;
		l = jd + 68569;
		n = (4 * l) / 146097;
		l = l - (146097 * n + 3) / 4;
		i = (4000 * (l + 1)) / 1461001;
		l = l - (1461 * i) / 4 + 31;
		j = (80 * l) / 2447;
		k = j / 11;
		return 100 * (n - 49) + i + k;
	endfunction

	function automatic conv_out_t convert_timestamp(conv_in_t w);
		conv_out_t r;
		longint    n4, day, jd_in, first, yi, doy, year, jd, off, n, d, ly;
		r = '0;
		r.day_millis_out = w.day_millis_in;
		n4 = w.interval_number;
		day = w.interval_day;
		jd_in = w.julian_day_in;
		if (w.op == OP_TO_JD) begin
			if (n4 < 1) begin
				r.error_code = ERR_INTERVAL;
			end else begin
				// the interval starting 2100 has a common first year
				first = (n4 == 27) ? 365 : 366;
				if (day <= first) begin
					yi = 0;
					doy = day;
				end else if (day <= first + 365) begin
					yi = 1;
					doy = day - first;
				end else if (day <= first + 730) begin
					yi = 2;
					doy = day - (first + 365);
				end else begin
					yi = 3;
					doy = day - (first + 730);
				end
				year = 1996 + 4 * (n4 - 1) + yi;
				jd = jan1_julian(year) + doy - 1;
				r.julian_day_out = jd[21:0];
			end
		end else begin
			year = year_of_julian(jd_in);
			if (year < 1996) begin
				r.error_code = ERR_EARLY_YEAR;
			end else begin
				off = year - 1996;
				n = 1 + off / 4;
				if (n > 31) begin
					r.error_code = ERR_INTERVAL;
				end else begin
					yi = off % 4;
					d = yi * 365;
					if (yi > 0) begin
						ly = year - (year % 4);
						if ((ly % 400) == 0 || (ly % 100) != 0)
							d = d + 1;
					end
					d = d + jd_in - jan1_julian(year) + 1;
					r.interval_out = n[4:0];
					r.interval_day_out = d[10:0];
				end
			end
		end
		return r;
	endfunction

	function automatic conv_in_t make_word(op_t op, int n4, int day, longint jd, int ms);
		conv_in_t w;
		w.op = op;
		w.interval_number = n4[4:0];
		w.interval_day = day[10:0];
		w.julian_day_in = jd[21:0];
		w.day_millis_in = ms[26:0];
		return w;
	endfunction

	function automatic int random_millis();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 27'h7FFFFFF);
		return $urandom_range(0, DAY_MS - 1);
	endfunction

	function automatic conv_in_t random_word();
		conv_in_t w;
		int       pick;
		longint   y;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			w = make_word(OP_TO_JD, $urandom_range(1, 31), $urandom_range(1, 1461),
				$urandom_range(0, 22'h3FFFFF), random_millis());
		end else if (pick < 70) begin
			w = make_word(OP_FROM_JD, $urandom_range(0, 31), $urandom_range(0, 2047),
				$urandom_range(JAN1_1996, JD_LIMIT - 1), random_millis());
		end else if (pick < 85) begin
			// around New Year, including the ends of the valid span
			y = $urandom_range(1995, 2121);
			w = make_word(OP_FROM_JD, $urandom_range(0, 31), $urandom_range(0, 2047),
				jan1_julian(y) + $urandom_range(0, 4) - 2, random_millis());
		end else begin
			w.julian_day_in = 22'($urandom());
			w.day_millis_in = 27'($urandom());
			w.interval_day = 11'($urandom());
			w.interval_number = 5'($urandom());
			w.op = 1'($urandom());
		end
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic send_word(input conv_in_t w);
		conv_out_t r;
		start <= 1'b1;
		request <= w;
		do @(posedge clk); while (busy !== 1'b0);
		r = convert_timestamp(w);
		conversions_in_flight.push_back(r);
		if (w.op == OP_TO_JD)
			to_jd_words++;
		else
			from_jd_words++;
		if (r.error_code == ERR_EARLY_YEAR)
			early_year_words++;
		if (r.error_code == ERR_INTERVAL)
			bad_interval_words++;
	endtask

	task automatic idle_burst();
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic wait_for_drain();
		while (conversions_in_flight.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_edges();
		send_word(make_word(OP_TO_JD, 0, 100, 0, 0));
		send_word(make_word(OP_TO_JD, 1, 0, 0, DAY_MS - 1));
		send_word(make_word(OP_TO_JD, 1, 1, 22'h3FFFFF, 27'h7FFFFFF));
		send_word(make_word(OP_TO_JD, 1, 366, 0, 1));
		send_word(make_word(OP_TO_JD, 1, 367, 0, 0));
		send_word(make_word(OP_TO_JD, 1, 1461, 0, 12345));
		send_word(make_word(OP_TO_JD, 1, 2047, 0, 0));
		send_word(make_word(OP_TO_JD, 26, 1461, 0, 0));
		send_word(make_word(OP_TO_JD, 27, 365, 0, DAY_MS - 1));
		send_word(make_word(OP_TO_JD, 27, 366, 0, 0));
		send_word(make_word(OP_TO_JD, 27, 1461, 0, 0));
		send_word(make_word(OP_TO_JD, 31, 1461, 0, 0));
		send_word(make_word(OP_TO_JD, 31, 2047, 0, 27'h7FFFFFF));
		send_word(make_word(OP_FROM_JD, 0, 0, 0, 0));
		send_word(make_word(OP_FROM_JD, 31, 2047, 22'h3FFFFF, DAY_MS - 1));
		send_word(make_word(OP_FROM_JD, 0, 0, JAN1_1996 - 1, 0));
		send_word(make_word(OP_FROM_JD, 0, 0, JAN1_1996, 7));
		send_word(make_word(OP_FROM_JD, 0, 0, JD_LIMIT - 1, 0));
		send_word(make_word(OP_FROM_JD, 0, 0, JD_LIMIT, 0));
		send_word(make_word(OP_FROM_JD, 0, 0, jan1_julian(2100) - 1, 0));
		send_word(make_word(OP_FROM_JD, 0, 0, jan1_julian(2100), 0));
		send_word(make_word(OP_FROM_JD, 0, 0, jan1_julian(2101), 0));
		send_word(make_word(OP_FROM_JD, 0, 0, jan1_julian(2104), 0));
		send_word(make_word(OP_FROM_JD, 0, 0, jan1_julian(1997) - 1, 0));
	endtask

	task automatic test_random_with_gaps(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0)
				idle_odds = $urandom_range(0, 2) * 3;
			send_word(random_word());
			idle_burst();
		end
	endtask

	task automatic test_pause_until_drained();
		for (int i = 0; i < 20; i++)
			send_word(random_word());
		start <= 1'b0;
		wait_for_drain();
		for (int i = 0; i < 20; i++)
			send_word(random_word());
	endtask

	task automatic test_back_to_back(input int count);
		for (int i = 0; i < count; i++)
			send_word(random_word());
		start <= 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		conv_out_t want;
		if (arst_n && done === 1'b1) begin
			if (conversions_in_flight.size() == 0) begin
				report_mismatch("result strobed with no word outstanding");
			end else begin
				want = conversions_in_flight.pop_front();
				check_field("julian_day_out", result.julian_day_out, want.julian_day_out);
				check_field("interval_out", result.interval_out, want.interval_out);
				check_field("interval_day_out", result.interval_day_out,
					want.interval_day_out);
				check_field("day_millis_out", result.day_millis_out, want.day_millis_out);
				check_field("error_code", result.error_code, want.error_code);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		results_seen = 0;
		to_jd_words = 0;
		from_jd_words = 0;
		early_year_words = 0;
		bad_interval_words = 0;
		quiet_cycles = 0;
		idle_odds = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		request <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_edges();
		test_random_with_gaps(500);
		test_pause_until_drained();
		test_random_with_gaps(500);
		idle_odds = 0;
		test_back_to_back(360);

		wait_for_drain();
		repeat (8) @(posedge clk);
		$display("Converted %0d N4/day words and %0d Julian day words",
			to_jd_words, from_jd_words);
		$display("Error cases: %0d before 1996, %0d interval out of range",
			early_year_words, bad_interval_words);
		if (mismatches == 0 && conversions_in_flight.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
